FILE: hw/rtl/lbvh_child_interval_split_top_defines.svh
// Assertion macros shared by the LBVH interval split checker.
`ifndef LBVH_CHILD_INTERVAL_SPLIT_TOP_DEFINES_SVH
`define LBVH_CHILD_INTERVAL_SPLIT_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define LBVH_CIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LBVH_CIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lbvh_cis_pkg.sv
// Types and constants for the LBVH child interval split block.
package lbvh_cis_pkg;

  localparam int CODE_W      = 32;
  localparam int IDX_W       = 13;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_RDLO,
    S_RDHI,
    S_REF,
    S_ITER,
    S_CMP,
    S_INS,
    S_EMIT
  } state_t;

endpackage

FILE: hw/rtl/lbvh_child_interval_split_top.sv
// LBVH child interval splitter over a sorted Morton code store.
//
// Input stream (s_*): s_tuser is the command. A write word (0) puts
// code_value at code_index; indices at or past STORE_DEPTH are dropped.
// A query word (1) names [interval_start, interval_end); empty, reversed
// or out-of-store queries give nothing.
// Output stream (m_*): one word per child interval in index order, with
// m_tlast on the final child; a length-one query returns itself.
// Flow: words are taken only in the idle state. Per split, a query scans
// the current children (one per cycle), reads the two end codes (S_RDLO,
// S_RDHI, S_REF), runs about ceil(log2(len)) binary search steps, each an
// S_ITER read and an S_CMP compare as the single read port is registered
// (none if the end codes match: the split is then the midpoint), and
// inserts; it then emits one child per cycle while m_tready is high.
// Reset clears control state only; the code store is undefined until
// written. While m_tready is low the output word is held and emission
// waits; a new word is still accepted once the block is idle.
module lbvh_child_interval_split_top #(
  parameter int TREE_WIDTH  = 4,
  parameter int STORE_DEPTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // code_index[11:0], code_value[43:12], interval_start[55:44],
  // interval_end[68:56], zero[71:69]
  input  logic [lbvh_cis_pkg::IN_TDATA_W-1:0] s_tdata,
  // cmd[0]
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // child_start[11:0], child_end[24:12], zero[31:25]
  output logic [lbvh_cis_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                                m_tlast
);
  import lbvh_cis_pkg::*;

  localparam int NW = $clog2(TREE_WIDTH + 1);
  localparam int AW = $clog2(STORE_DEPTH);

  state_t state, state_next;

  logic [CODE_W-1:0] mem [STORE_DEPTH];
  logic [CODE_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;

  logic [IDX_W-1:0] bnd [TREE_WIDTH+1];
  logic [NW-1:0]    count, want, idx, best;
  logic [IDX_W-1:0] prev, best_lo, best_hi, best_size;
  logic [IDX_W-1:0] s_pos, step, split;
  logic [IDX_W:0]   cand;
  logic             cand_ok;
  logic [CODE_W-1:0] code_lo, mask;

  logic [11:0]      out_start;
  logic [IDX_W-1:0] out_end;

  cmd_t             in_cmd;
  logic [11:0]      in_index;
  logic [CODE_W-1:0] in_value;
  logic [IDX_W-1:0] in_start, in_end, q_len;
  logic [NW-1:0]    q_want;
  logic             in_fire, q_ok, wr_ok, out_load;

  logic [IDX_W-1:0] cur, sz, hi_idx, mid;
  logic [IDX_W:0]   step_sum, cand_c;
  logic [IDX_W-1:0] step_n, s_new;
  logic [CODE_W-1:0] diff, smear;
  logic             take;
  logic [NW-1:0]    idx_inc;

  assign in_cmd   = cmd_t'(s_tuser);
  assign in_index = s_tdata[11:0];
  assign in_value = s_tdata[43:12];
  assign in_start = {1'b0, s_tdata[55:44]};
  assign in_end   = s_tdata[68:56];
  assign in_fire  = s_tvalid && s_tready;
  assign q_len    = in_end - in_start;
  assign q_ok     = (in_end > in_start) && (32'(in_end) <= 32'(STORE_DEPTH));
  assign wr_ok    = 32'(in_index) < 32'(STORE_DEPTH);
  assign q_want   = (q_len < IDX_W'(TREE_WIDTH)) ? NW'(q_len) : NW'(TREE_WIDTH);

  assign idx_inc  = NW'(idx + 1'b1);
  assign cur      = bnd[idx];
  assign sz       = cur - prev;
  assign hi_idx   = best_hi - 1'b1;
  assign mid      = IDX_W'(({1'b0, best_lo} + {1'b0, hi_idx}) >> 1);
  assign step_sum = {1'b0, step} + 1'b1;
  assign step_n   = step_sum[IDX_W:1];
  assign cand_c   = {1'b0, s_pos} + {1'b0, step_n};
  assign take     = cand_ok && (((rd_data ^ code_lo) & mask) == '0);
  assign s_new    = take ? cand[IDX_W-1:0] : s_pos;
  assign out_load = (state == S_EMIT) && (!m_tvalid || m_tready);

  always_comb begin
    diff  = code_lo ^ rd_data;
    smear = diff;
    for (int sh = 1; sh < CODE_W; sh = sh * 2) begin
      smear = smear | (smear >> sh);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && in_cmd == CMD_QUERY && q_ok) begin
          state_next = (q_want > NW'(1)) ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: if (idx == count) state_next = S_RDLO;
      S_RDLO: state_next = S_RDHI;
      S_RDHI: state_next = S_REF;
      S_REF:  state_next = (rd_data == code_lo) ? S_INS : S_ITER;
      S_ITER: state_next = S_CMP;
      S_CMP:  state_next = (step > IDX_W'(1)) ? S_ITER : S_INS;
      S_INS:  state_next = (NW'(count + 1'b1) < want) ? S_SCAN : S_EMIT;
      S_EMIT: if (out_load && idx_inc == count) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    s_tready = 1'b0;
    mem_we   = 1'b0;
    rd_addr  = '0;
    case (state)
      S_IDLE: begin
        s_tready = !rst;
        mem_we   = in_fire && in_cmd == CMD_WRITE && wr_ok;
      end
      S_RDLO:  rd_addr = AW'(best_lo);
      S_RDHI:  rd_addr = AW'(hi_idx);
      S_ITER:  rd_addr = AW'(cand_c);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(in_index)] <= in_value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire && in_cmd == CMD_QUERY) begin
          bnd[0]    <= in_start;
          bnd[1]    <= in_end;
          count     <= NW'(1);
          want      <= q_want;
          prev      <= in_start;
          best_size <= '0;
          idx       <= (q_want > NW'(1)) ? NW'(1) : '0;
        end
      end
      S_SCAN: begin
        if (sz > best_size) begin
          best_size <= sz;
          best      <= NW'(idx - 1'b1);
          best_lo   <= prev;
          best_hi   <= cur;
        end
        prev <= cur;
        idx  <= idx_inc;
      end
      S_RDHI: code_lo <= rd_data;
      S_REF: begin
        mask  <= ~(smear >> 1);
        s_pos <= best_lo;
        step  <= hi_idx - best_lo;
        split <= mid;
      end
      S_ITER: begin
        step    <= step_n;
        cand    <= cand_c;
        cand_ok <= cand_c < {1'b0, hi_idx};
      end
      S_CMP: begin
        s_pos <= s_new;
        split <= s_new;
      end
      S_INS: begin
        for (int j = 1; j <= TREE_WIDTH; j++) begin
          if (j == int'(best) + 1) begin
            bnd[j] <= split + 1'b1;
          end else if (j > int'(best) + 1 && j <= int'(count) + 1) begin
            bnd[j] <= bnd[j-1];
          end
        end
        count     <= NW'(count + 1'b1);
        prev      <= bnd[0];
        best_size <= '0;
        idx       <= (NW'(count + 1'b1) < want) ? NW'(1) : '0;
      end
      S_EMIT: begin
        if (out_load) begin
          out_start <= prev[11:0];
          out_end   <= bnd[idx_inc];
          m_tlast   <= (idx_inc == count);
          prev      <= bnd[idx_inc];
          idx       <= idx_inc;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {(OUT_TDATA_W - 25)'(0), out_end, out_start};

endmodule

FILE: hw/rtl/lbvh_cis_checker.sv
// Port-level checker for the LBVH child interval splitter, with its bind.
`include "lbvh_child_interval_split_top_defines.svh"

module lbvh_cis_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  logic        out_stall;
  logic [32:0] out_word;
  logic [12:0] child_lo;
  logic        wr_idle;

  assign out_stall = m_tvalid && !m_tready;
  assign out_word  = {m_tlast, m_tdata};
  assign child_lo  = 13'(m_tdata[11:0]);
  assign wr_idle   = s_tvalid && s_tready && !s_tuser && !m_tvalid;

  `LBVH_CIS_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid, "output word dropped")
  `LBVH_CIS_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_word), "word changed in stall")
  `LBVH_CIS_ASSERT_NOW(a_child_nonempty, m_tvalid, m_tdata[24:12] > child_lo, "empty child")
  `LBVH_CIS_ASSERT_NEXT(a_write_silent, wr_idle, !m_tvalid, "write word gave output")

endmodule

bind lbvh_child_interval_split_top lbvh_cis_checker u_checker (.*);
